>>> hdl/bps_pkg.sv
// package for the bus poll sequencer: beat types, event and phase codes,
// register indexes and defaults; depends on nothing
package bps_pkg;

  // largest device count honored, a larger device_count is clamped to this
  localparam int unsigned MaxDevices = 32;
  localparam int unsigned TimeBitsDefault = 22;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_DEVICE_COUNT = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_QUERY_GAP    = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT      = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] REG_POLL_PERIOD  = CfgIdxW'(3);

  // register reset values
  localparam logic [5:0]  DEVICE_COUNT_RST = 6'd0;
  localparam logic [15:0] QUERY_GAP_RST    = 16'd100;
  localparam logic [21:0] TIMEOUT_RST      = 22'd5000;
  localparam logic [21:0] POLL_PERIOD_RST  = 22'd10000;

  // event kinds
  localparam logic [2:0] EV_ISSUED  = 3'd0;
  localparam logic [2:0] EV_SUCCESS = 3'd1;
  localparam logic [2:0] EV_FAIL    = 3'd2;
  localparam logic [2:0] EV_TIMEOUT = 3'd3;
  localparam logic [2:0] EV_DONE    = 3'd4;

  // phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_START   = 3'd1;
  localparam logic [2:0] PH_WAIT    = 3'd2;
  localparam logic [2:0] PH_PROCESS = 3'd3;
  localparam logic [2:0] PH_WAITING = 3'd4;

  typedef struct packed {
    logic request_accepted;
    logic response_ready;
  } tick_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [4:0] device_index;
    logic       last_event;
  } event_t;

endpackage

>>> hdl/bus_poll_sequencer.sv
// bus poll sequencer top level: round-robin device poll scheduler with timeout
// depends on bps_pkg for beat types, codes and register defaults
//
//  channel | handshake                  | beat
//  --------+----------------------------+----------------------------------
//  tick in | in_valid_i / in_ready_o    | in_data_i  (bps_pkg::tick_t)
//  events  | out_valid_o / out_ready_i  | out_data_o (bps_pkg::event_t)
//  config  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// a tick's zero to three events are computed in the cycle in which it is taken
// and written into a four-entry event queue, shown from the next cycle on;
// ticks follow back to back while at most one event remains queued after
// this cycle's beat, else in_ready_o drops. reset clears phase, device index,
// both counters and the queue, and loads the register defaults. config is
// always ready.
module bus_poll_sequencer #(
  parameter int unsigned TIME_BITS = bps_pkg::TimeBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bps_pkg::tick_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bps_pkg::event_t               out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bps_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bps_pkg::*;

  localparam int unsigned CmpW   = (TIME_BITS > 22) ? TIME_BITS : 22;
  localparam int unsigned Depth  = 4;
  localparam int unsigned PtrW   = 2;
  localparam int unsigned CntW   = 3;
  localparam int unsigned MaxEv  = 3;
  localparam logic [TIME_BITS-1:0] TimeMax = {TIME_BITS{1'b1}};

  // configuration registers
  logic [5:0]  dev_count_q;
  logic [15:0] gap_q;
  logic [21:0] timeout_q;
  logic [21:0] period_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_count_q <= DEVICE_COUNT_RST;
      gap_q       <= QUERY_GAP_RST;
      timeout_q   <= TIMEOUT_RST;
      period_q    <= POLL_PERIOD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DEVICE_COUNT: dev_count_q <= cfg_data_i[5:0];
        REG_QUERY_GAP:    gap_q       <= cfg_data_i[15:0];
        REG_TIMEOUT:      timeout_q   <= cfg_data_i[21:0];
        REG_POLL_PERIOD:  period_q    <= cfg_data_i[21:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [2:0]           phase_q, phase_d;
  logic [5:0]           cur_q, cur_d;
  logic [TIME_BITS-1:0] sa_q, sa_d, sq_q, sq_d;

  // event queue
  event_t             fifo_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    cnt_q;

  logic in_fire, pop;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];
  // room for a whole tick's events once this cycle's pop is counted
  assign in_ready_o  = (cnt_q - CntW'(pop)) <= CntW'(Depth - MaxEv);
  assign in_fire     = in_valid_i && in_ready_o;

  // counters advance at the start of each tick and saturate
  logic [TIME_BITS-1:0] sa_inc, sq_inc;
  assign sa_inc = (sa_q == TimeMax) ? sa_q : sa_q + 1'b1;
  assign sq_inc = (sq_q == TimeMax) ? sq_q : sq_q + 1'b1;

  logic [6:0] eff_cnt, nxt_dev;
  logic       sa_ge_gap, sa_ge_period, sq_gt_to, adv_done, start_done;

  always_comb begin
    if ({3'b000, dev_count_q} > 9'(MaxDevices)) begin
      eff_cnt = 7'(MaxDevices);
    end else begin
      eff_cnt = {1'b0, dev_count_q};
    end
  end

  assign nxt_dev      = {1'b0, cur_q} + 7'd1;
  assign adv_done     = nxt_dev >= eff_cnt;
  assign start_done   = {1'b0, cur_q} >= eff_cnt;
  assign sa_ge_gap    = CmpW'(sa_inc) >= CmpW'(gap_q);
  assign sa_ge_period = CmpW'(sa_inc) >= CmpW'(period_q);
  assign sq_gt_to     = CmpW'(sq_inc) >  CmpW'(timeout_q);

  event_t     ev [MaxEv];
  logic [1:0] ev_cnt;
  logic [2:0] kind0, kind1, kind2;

  always_comb begin
    phase_d = phase_q;
    cur_d   = cur_q;
    sa_d    = sa_inc;
    sq_d    = sq_inc;
    ev_cnt  = 2'd0;
    kind0   = EV_ISSUED;
    kind1   = EV_DONE;
    kind2   = EV_DONE;
    unique case (phase_q)
      PH_START: begin
        if (start_done) begin
          kind0   = EV_DONE;
          ev_cnt  = 2'd1;
          phase_d = PH_WAITING;
          sa_d    = '0;
        end else if (sa_ge_gap) begin
          sa_d  = '0;
          sq_d  = '0;
          kind0 = EV_ISSUED;
          if (in_data_i.request_accepted) begin
            ev_cnt  = 2'd1;
            phase_d = PH_WAIT;
          end else begin
            kind1 = EV_FAIL;
            cur_d = nxt_dev[5:0];
            if (adv_done) begin
              ev_cnt  = 2'd3;
              phase_d = PH_WAITING;
            end else begin
              ev_cnt  = 2'd2;
              phase_d = PH_START;
            end
          end
        end
      end
      PH_WAIT, PH_PROCESS: begin
        if (phase_q == PH_PROCESS || sq_gt_to) begin
          kind0 = (phase_q == PH_PROCESS) ? EV_SUCCESS : EV_TIMEOUT;
          cur_d = nxt_dev[5:0];
          if (adv_done) begin
            ev_cnt  = 2'd2;
            phase_d = PH_WAITING;
            sa_d    = '0;
          end else begin
            ev_cnt  = 2'd1;
            phase_d = PH_START;
          end
        end else if (in_data_i.response_ready) begin
          phase_d = PH_PROCESS;
        end
      end
      PH_WAITING: begin
        if (sa_ge_period) begin
          phase_d = PH_START;
          cur_d   = '0;
          sa_d    = '0;
        end
      end
      default: begin
        // idle and unused codes
        phase_d = PH_START;
        cur_d   = '0;
        sa_d    = '0;
      end
    endcase
  end

  // device index of the done event is 0, all others carry the current device
  always_comb begin
    ev[0].event_kind   = kind0;
    ev[0].device_index = (kind0 == EV_DONE) ? 5'd0 : cur_q[4:0];
    ev[0].last_event   = (ev_cnt == 2'd1);
    ev[1].event_kind   = kind1;
    ev[1].device_index = (kind1 == EV_DONE) ? 5'd0 : cur_q[4:0];
    ev[1].last_event   = (ev_cnt == 2'd2);
    ev[2].event_kind   = kind2;
    ev[2].device_index = 5'd0;
    ev[2].last_event   = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cur_q   <= '0;
      sa_q    <= '0;
      sq_q    <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      cur_q   <= cur_d;
      sa_q    <= sa_d;
      sq_q    <= sq_d;
    end
  end

  logic [1:0] push_cnt;
  assign push_cnt = in_fire ? ev_cnt : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_cnt);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      cnt_q    <= cnt_q + CntW'(push_cnt) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxEv; k++) begin
      if (2'(k) < push_cnt) begin
        fifo_q[wr_ptr_q + PtrW'(k)] <= ev[k];
      end
    end
  end

  // queue never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("event queue count above depth");

  // a tick is only taken when all its events fit
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (cnt_q - CntW'(pop) + CntW'(ev_cnt)) <= CntW'(Depth))
    else $error("event queue overflow");

  // a tick that yields events makes the event port valid next cycle
  a_ev_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && ev_cnt != 2'd0) |=> out_valid_o)
    else $error("events of a tick not presented");

  // entering the post-cycle wait always reports cycle complete
  a_done_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_d == PH_WAITING && phase_q != PH_WAITING) |-> ev_cnt != 2'd0)
    else $error("cycle ended without done event");

endmodule
